// ===== src/sdma_pkg.sv =====
// ----------------------------------------------------------------------------
// sdma_pkg
// shared widths, reset values, register indexes and the result record
// ----------------------------------------------------------------------------
package sdma_pkg;

    localparam int DEF_GROUP_SIZE = 10;
    localparam int DEF_RING_DEPTH = 2048;
    localparam int QUEUE_DEPTH    = 2;

    localparam int SAMPLE_W   = 16;
    localparam int HEIGHT_W   = 17;
    localparam int WLEN_W     = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LEVEL    = 1'd1;

    localparam logic [WLEN_W-1:0]   RESET_WINDOW_LENGTH = 12'd100;
    localparam logic [SAMPLE_W-1:0] RESET_ZERO_LEVEL    = 16'd15516;
    localparam logic signed [HEIGHT_W-1:0] HEIGHT_MAX   = 17'sd65535;
    localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN   = -17'sd65535;

    typedef struct packed {
        logic [SAMPLE_W-1:0]        averaged_level;
        logic signed [HEIGHT_W-1:0] height;
        logic signed [HEIGHT_W-1:0] lowest_height;
        logic signed [HEIGHT_W-1:0] highest_height;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

// ===== src/sdma_fifo.sv =====
// ----------------------------------------------------------------------------
// sdma_fifo
// small register queue, one push and one pop per cycle; a push while full or a pop while empty is ignored
// ----------------------------------------------------------------------------
module sdma_fifo
    import sdma_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_empty   = (r_cnt == '0);
    assign o_full    = (r_cnt == CNT_W'(DEPTH));
    assign o_data    = r_mem[r_rp];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_do_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== src/sdma_front.sv =====
// ----------------------------------------------------------------------------
// sdma_front
// collects samples into groups and hands each complete group sum onward
// ----------------------------------------------------------------------------
module sdma_front
    import sdma_pkg::*;
#(
    parameter int GROUP_SIZE = DEF_GROUP_SIZE,
    parameter int GSUM_W     = SAMPLE_W + $clog2(GROUP_SIZE)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_push,
    output logic [GSUM_W-1:0]   o_sum
);

    localparam int GCNT_W = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;

    logic [GSUM_W-1:0] r_gsum;
    logic [GCNT_W-1:0] r_gcnt;
    logic [GSUM_W-1:0] n_gsum;
    logic              w_last;

    assign n_gsum = r_gsum + GSUM_W'(i_sample);
    assign w_last = (r_gcnt == GCNT_W'(GROUP_SIZE - 1));
    assign o_push = i_valid && w_last;
    assign o_sum  = n_gsum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gsum <= '0;
            r_gcnt <= '0;
        end else if (i_valid) begin
            if (w_last) begin
                r_gsum <= '0;
                r_gcnt <= '0;
            end else begin
                r_gsum <= n_gsum;
                r_gcnt <= r_gcnt + 1'b1;
            end
        end
    end

endmodule

// ===== src/sdma_div.sv =====
// ----------------------------------------------------------------------------
// sdma_div
// restoring serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sdma_div
    import sdma_pkg::*;
#(
    parameter int DIV_W = 27,
    parameter int DVS_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   w_trial;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    assign w_trial    = {r_rem, r_quo[DIV_W-1]};
    assign w_diff     = w_trial - {1'b0, r_dvs};
    assign w_ge       = (w_trial >= {1'b0, r_dvs});
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
        end
    end

endmodule

// ===== src/sdma_back.sv =====
// ----------------------------------------------------------------------------
// sdma_back
// block value, ring store, moving mean, height and running extremes
// ----------------------------------------------------------------------------
module sdma_back
    import sdma_pkg::*;
#(
    parameter int GROUP_SIZE = DEF_GROUP_SIZE,
    parameter int RING_DEPTH = DEF_RING_DEPTH,
    parameter int GSUM_W     = SAMPLE_W + $clog2(GROUP_SIZE),
    parameter int DIV_W      = 27,
    parameter int DVS_W      = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_gsum_avail,
    input  logic [GSUM_W-1:0]     i_gsum,
    output logic                  o_gsum_pop,
    input  logic                  i_res_full,
    output logic                  o_res_push,
    output t_result               o_res,
    output logic                  o_div_start,
    output logic [DIV_W-1:0]      o_div_dividend,
    output logic [DVS_W-1:0]      o_div_divisor,
    input  logic                  i_div_done,
    input  logic [DIV_W-1:0]      i_div_quo
);

    localparam int PW     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW     = $clog2(RING_DEPTH + 1);
    localparam int RSUM_W = SAMPLE_W + $clog2(RING_DEPTH);
    localparam int LEN_W  = WLEN_W + 1;

    // group sum / GROUP_SIZE by reciprocal multiply, exact for every group sum
    localparam int BLK_SH  = GSUM_W + $clog2(GROUP_SIZE);
    localparam int RECIP_W = BLK_SH + 1;
    localparam int PROD_W  = GSUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] BLK_RECIP =
        RECIP_W'(((64'd1 << BLK_SH) + 64'(GROUP_SIZE) - 64'd1) / 64'(GROUP_SIZE));

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_READ    = 4'b0010,
        ST_UPDATE  = 4'b0100,
        ST_DIV_AVG = 4'b1000
    } t_back_state;

    t_back_state r_state;
    logic [WLEN_W-1:0]          r_wlen;
    logic [SAMPLE_W-1:0]        r_zero;
    logic [PW-1:0]              r_pos;
    logic [RSUM_W-1:0]          r_rsum;
    logic                       r_filled;
    logic signed [HEIGHT_W-1:0] r_min;
    logic signed [HEIGHT_W-1:0] r_max;
    logic [SAMPLE_W-1:0]        r_blk;
    logic [SAMPLE_W-1:0]        r_old;
    logic [SAMPLE_W-1:0]        r_ring [RING_DEPTH];

    logic [CW-1:0]              w_len;
    logic [CW-1:0]              w_next;
    logic [CW-1:0]              w_count;
    logic [RSUM_W-1:0]          n_rsum;
    logic [SAMPLE_W-1:0]        w_level;
    logic signed [HEIGHT_W-1:0] w_height;
    logic signed [HEIGHT_W-1:0] n_min;
    logic signed [HEIGHT_W-1:0] n_max;
    logic                       w_start;
    logic [PROD_W-1:0]          w_blk_prod;
    logic [SAMPLE_W-1:0]        w_blk;

    always_comb begin
        if (r_wlen == '0) begin
            w_len = CW'(1);
        end else if ({1'b0, r_wlen} > LEN_W'(RING_DEPTH)) begin
            w_len = CW'(RING_DEPTH);
        end else begin
            w_len = CW'(r_wlen);
        end
    end

    assign w_blk_prod = PROD_W'(i_gsum) * PROD_W'(BLK_RECIP);
    assign w_blk      = w_blk_prod[BLK_SH +: SAMPLE_W];

    assign w_next   = CW'(r_pos) + 1'b1;
    assign w_count  = r_filled ? w_len : w_next;
    assign n_rsum   = r_rsum - (r_filled ? RSUM_W'(r_old) : '0) + RSUM_W'(r_blk);
    assign w_level  = i_div_quo[SAMPLE_W-1:0];
    assign w_height = $signed({1'b0, w_level}) - $signed({1'b0, r_zero});
    assign n_min    = (w_height < r_min) ? w_height : r_min;
    assign n_max    = (w_height > r_max) ? w_height : r_max;
    assign w_start  = (r_state == ST_IDLE) && i_gsum_avail && !i_res_full;

    assign o_gsum_pop     = w_start;
    assign o_div_start    = (r_state == ST_UPDATE);
    assign o_div_dividend = DIV_W'(n_rsum);
    assign o_div_divisor  = DVS_W'(w_count);

    assign o_res_push           = (r_state == ST_DIV_AVG) && i_div_done;
    assign o_res.averaged_level = w_level;
    assign o_res.height         = w_height;
    assign o_res.lowest_height  = n_min;
    assign o_res.highest_height = n_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_wlen   <= RESET_WINDOW_LENGTH;
            r_zero   <= RESET_ZERO_LEVEL;
            r_pos    <= '0;
            r_rsum   <= '0;
            r_filled <= 1'b0;
            r_min    <= HEIGHT_MAX;
            r_max    <= HEIGHT_MIN;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_start) begin
                        if (CW'(r_pos) >= w_len) begin
                            r_pos <= '0;
                        end
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    r_rsum <= n_rsum;
                    if (w_next >= w_len) begin
                        r_pos    <= '0;
                        r_filled <= 1'b1;
                    end else begin
                        r_pos <= w_next[PW-1:0];
                    end
                    r_state <= ST_DIV_AVG;
                end
                ST_DIV_AVG: begin
                    if (i_div_done) begin
                        r_min   <= n_min;
                        r_max   <= n_max;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_WINDOW_LENGTH: begin
                        r_wlen   <= i_cfg_data[WLEN_W-1:0];
                        r_pos    <= '0;
                        r_rsum   <= '0;
                        r_filled <= 1'b0;
                    end
                    REG_ZERO_LEVEL: begin
                        r_zero <= i_cfg_data[SAMPLE_W-1:0];
                    end
                    default: begin
                        r_zero <= r_zero;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_blk <= w_blk;
        end
    end

    // ring store, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_old <= r_ring[r_pos];
        end
        if (r_state == ST_UPDATE) begin
            r_ring[r_pos] <= r_blk;
        end
    end

endmodule

// ===== src/sensor_decimate_moving_average_top.sv =====
// ----------------------------------------------------------------------------
// sensor_decimate_moving_average_top
// group decimator feeding a moving average with height and extremes
//
//   channel   handshake          payload
//   samples   push / full        i_bridge_sample
//   results   pop / empty        o_averaged_level, o_height,
//                                o_lowest_height, o_highest_height
//   config    i_cfg_we           i_cfg_idx, i_cfg_data
//
// a sample is taken on each push while full is low; every GROUP_SIZE-th
// sample queues a group sum for the back end, which takes one group sum
// at a time and waits on the serial divider for the mean
// reset is synchronous; the ring store needs no clearing pass, since an
// entry is only used after it has been written in the current window
// full rises when the group queue is full; results wait in their own queue
// ----------------------------------------------------------------------------
module sensor_decimate_moving_average_top
    import sdma_pkg::*;
#(
    parameter int GROUP_SIZE = DEF_GROUP_SIZE,
    parameter int RING_DEPTH = DEF_RING_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [SAMPLE_W-1:0]        i_bridge_sample,
    input  logic                       pop,
    output logic                       empty,
    output logic [SAMPLE_W-1:0]        o_averaged_level,
    output logic signed [HEIGHT_W-1:0] o_height,
    output logic signed [HEIGHT_W-1:0] o_lowest_height,
    output logic signed [HEIGHT_W-1:0] o_highest_height,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int GSUM_W = SAMPLE_W + $clog2(GROUP_SIZE);
    localparam int CW     = $clog2(RING_DEPTH + 1);
    localparam int RSUM_W = SAMPLE_W + $clog2(RING_DEPTH);
    localparam int DIV_W  = RSUM_W;
    localparam int DVS_W  = CW;

    logic              w_accept;
    logic              w_grp_push;
    logic [GSUM_W-1:0] w_grp_sum;
    logic [GSUM_W-1:0] w_grp_head;
    logic              w_grp_empty;
    logic              w_grp_pop;
    logic              w_res_full;
    logic              w_res_push;
    t_result           w_res;
    logic [RESULT_W-1:0] w_res_head;
    t_result           w_res_out;
    logic              w_div_start;
    logic [DIV_W-1:0]  w_div_dividend;
    logic [DVS_W-1:0]  w_div_divisor;
    logic              w_div_done;
    logic [DIV_W-1:0]  w_div_quo;

    assign w_accept = push && !full;

    sdma_front #(
        .GROUP_SIZE (GROUP_SIZE),
        .GSUM_W     (GSUM_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_accept),
        .i_sample (i_bridge_sample),
        .o_push   (w_grp_push),
        .o_sum    (w_grp_sum)
    );

    sdma_fifo #(
        .WIDTH (GSUM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_grp_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_grp_push),
        .i_data  (w_grp_sum),
        .i_pop   (w_grp_pop),
        .o_data  (w_grp_head),
        .o_empty (w_grp_empty),
        .o_full  (full)
    );

    sdma_div #(
        .DIV_W (DIV_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    sdma_back #(
        .GROUP_SIZE (GROUP_SIZE),
        .RING_DEPTH (RING_DEPTH),
        .GSUM_W     (GSUM_W),
        .DIV_W      (DIV_W),
        .DVS_W      (DVS_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_gsum_avail   (!w_grp_empty),
        .i_gsum         (w_grp_head),
        .o_gsum_pop     (w_grp_pop),
        .i_res_full     (w_res_full),
        .o_res_push     (w_res_push),
        .o_res          (w_res),
        .o_div_start    (w_div_start),
        .o_div_dividend (w_div_dividend),
        .o_div_divisor  (w_div_divisor),
        .i_div_done     (w_div_done),
        .i_div_quo      (w_div_quo)
    );

    sdma_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .i_pop   (pop),
        .o_data  (w_res_head),
        .o_empty (empty),
        .o_full  (w_res_full)
    );

    assign w_res_out        = t_result'(w_res_head);
    assign o_averaged_level = w_res_out.averaged_level;
    assign o_height         = w_res_out.height;
    assign o_lowest_height  = w_res_out.lowest_height;
    assign o_highest_height = w_res_out.highest_height;

endmodule
